@@ design/foct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foct_pkg
// Shared types and constants of the fading obstacle circle table.
// ----------------------------------------------------------------------------
package foct_pkg;

    localparam int CAP_DEFAULT = 32;
    localparam logic [31:0] FADE_RESET = 32'd15000;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 2;
    localparam int CNT_OUT_W   = 6;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_DUP      = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_QUERY    = 2'd3;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef struct packed {
        logic [31:0] stamp;
        logic [11:0] radius;
        logic [15:0] cy;
        logic [15:0] cx;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FADE_RD,
        S_FADE_CHK,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load_item;
        logic fade_issue;
        logic fade_pop;
        logic scan_run;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic is_query;
        logic count_zero;
        logic age_over;
        logic scan_done;
        logic out_free;
    } sts_t;

endpackage

@@ design/foct_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foct_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module foct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/foct_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foct_ctrl
// Sequencer: fade pass, table scan, result hand-off.
// ----------------------------------------------------------------------------
module foct_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  foct_pkg::sts_t  sts,
    output foct_pkg::cmd_t  cmd
);

    import foct_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_FADE_RD;
                end
            end
            S_FADE_RD:
            begin
                if (sts.is_query || sts.count_zero)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_FADE_CHK;
                end
            end
            S_FADE_CHK:
            begin
                if (sts.age_over)
                begin
                    state_next = S_FADE_RD;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready     = 1'b1;
                cmd.load_item = req_valid;
            end
            S_FADE_RD:
            begin
                cmd.fade_issue = !(sts.is_query || sts.count_zero);
            end
            S_FADE_CHK:
            begin
                cmd.fade_pop = sts.age_over;
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
            end
            S_DONE:
            begin
                cmd.finish = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ design/foct_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foct_datapath
// Circle ring storage, fade/duplicate/containment checks, result register.
// ----------------------------------------------------------------------------
module foct_datapath #(
    parameter int CAPACITY = foct_pkg::CAP_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  foct_pkg::cmd_t                      cmd,
    output foct_pkg::sts_t                      sts,
    input  logic                                cfg_we,
    input  logic [31:0]                         cfg_wdata,
    input  logic                                in_mode,
    input  logic [31:0]                         in_now_ms,
    input  logic signed [15:0]                  in_pos_x,
    input  logic signed [15:0]                  in_pos_y,
    input  logic [11:0]                         in_circle_radius,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          out_insert_status,
    output logic                                out_hit,
    output logic [foct_pkg::CNT_OUT_W-1:0]      out_faded_count,
    output logic [foct_pkg::CNT_OUT_W-1:0]      out_entry_count
);

    import foct_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = AW + 1;
    localparam int EW = $bits(entry_t);

    logic [31:0]        fade_reg;
    logic [AW-1:0]      oldest_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      k_reg;
    logic [CW-1:0]      faded_reg;
    logic               v1_reg;
    logic               v2_reg;
    logic               dup_reg;
    logic               hit_reg;

    logic               mode_reg;
    logic [31:0]        now_reg;
    logic signed [15:0] px_reg;
    logic signed [15:0] py_reg;
    logic [11:0]        rad_reg;

    logic [31:0]        dx2_reg;
    logic [31:0]        dy2_reg;
    logic [23:0]        r2_reg;

    logic               ov_reg;
    logic [1:0]         ost_reg;
    logic               ohit_reg;
    logic [CNT_OUT_W-1:0] ofade_reg;
    logic [CNT_OUT_W-1:0] ocnt_reg;

    logic [EW-1:0]      rdata;
    entry_t             ent;
    logic [AW-1:0]      raddr;
    logic [AW-1:0]      scan_slot;
    logic [AW-1:0]      tail_slot;
    logic [SW-1:0]      scan_sum;
    logic [SW-1:0]      tail_sum;
    logic               issue;
    logic [31:0]        age;
    logic               is_full;
    logic               do_write;
    logic [1:0]         status;
    logic [CW-1:0]      count_after;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [33:0] dx_sq;
    logic signed [33:0] dy_sq;
    logic [32:0]        d2;
    entry_t             wentry;

    assign ent = entry_t'(rdata);

    assign scan_sum  = SW'(oldest_reg) + SW'(k_reg);
    assign scan_slot = (scan_sum >= SW'(CAPACITY)) ? AW'(scan_sum - SW'(CAPACITY))
                                                   : AW'(scan_sum);
    assign tail_sum  = SW'(oldest_reg) + SW'(count_reg);
    assign tail_slot = (tail_sum >= SW'(CAPACITY)) ? AW'(tail_sum - SW'(CAPACITY))
                                                   : AW'(tail_sum);

    assign issue = cmd.scan_run && (k_reg != count_reg);
    assign raddr = cmd.fade_issue ? oldest_reg : scan_slot;

    assign age = now_reg - ent.stamp;

    assign dx    = {px_reg[15], px_reg} - {ent.cx[15], ent.cx};
    assign dy    = {py_reg[15], py_reg} - {ent.cy[15], ent.cy};
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;
    assign d2    = {1'b0, dx2_reg} + {1'b0, dy2_reg};

    assign is_full  = (count_reg == CW'(CAPACITY));
    assign do_write = cmd.finish && (mode_reg == MODE_INSERT) && !dup_reg && !is_full;

    always_comb
    begin
        priority if (mode_reg == MODE_QUERY)
        begin
            status = ST_QUERY;
        end
        else if (dup_reg)
        begin
            status = ST_DUP;
        end
        else if (is_full)
        begin
            status = ST_FULL;
        end
        else
        begin
            status = ST_INSERTED;
        end
    end

    assign count_after = (status == ST_INSERTED) ? count_reg + CW'(1) : count_reg;

    assign wentry.stamp  = now_reg;
    assign wentry.radius = rad_reg;
    assign wentry.cy     = py_reg;
    assign wentry.cx     = px_reg;

    foct_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (do_write),
        .waddr (tail_slot),
        .wdata (wentry),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign sts.is_query   = (mode_reg == MODE_QUERY);
    assign sts.count_zero = (count_reg == '0);
    assign sts.age_over   = (age > fade_reg);
    assign sts.scan_done  = (k_reg == count_reg) && !v1_reg && !v2_reg;
    assign sts.out_free   = !ov_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_reg   <= FADE_RESET;
            oldest_reg <= '0;
            count_reg  <= '0;
            k_reg      <= '0;
            faded_reg  <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            dup_reg    <= 1'b0;
            hit_reg    <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fade_reg <= cfg_wdata;
            end

            v1_reg <= issue;
            v2_reg <= v1_reg;

            if (cmd.load_item)
            begin
                k_reg     <= '0;
                faded_reg <= '0;
                dup_reg   <= 1'b0;
                hit_reg   <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    k_reg <= k_reg + CW'(1);
                end
                if (v1_reg && ent.cx == px_reg && ent.cy == py_reg)
                begin
                    dup_reg <= 1'b1;
                end
                if (v2_reg && d2 < {9'd0, r2_reg})
                begin
                    hit_reg <= 1'b1;
                end
            end

            if (cmd.fade_pop)
            begin
                oldest_reg <= (oldest_reg == AW'(CAPACITY - 1)) ? '0 : oldest_reg + AW'(1);
                count_reg  <= count_reg - CW'(1);
                faded_reg  <= faded_reg + CW'(1);
            end
            else if (cmd.finish)
            begin
                count_reg <= count_after;
            end

            if (cmd.finish)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg <= in_mode;
            now_reg  <= in_now_ms;
            px_reg   <= in_pos_x;
            py_reg   <= in_pos_y;
            rad_reg  <= in_circle_radius;
        end
        dx2_reg <= dx_sq[31:0];
        dy2_reg <= dy_sq[31:0];
        r2_reg  <= ent.radius * ent.radius;
        if (cmd.finish)
        begin
            ost_reg   <= status;
            ohit_reg  <= (mode_reg == MODE_QUERY) && hit_reg;
            ofade_reg <= CNT_OUT_W'(faded_reg);
            ocnt_reg  <= CNT_OUT_W'(count_after);
        end
    end

    assign out_valid         = ov_reg;
    assign out_insert_status = ost_reg;
    assign out_hit           = ohit_reg;
    assign out_faded_count   = ofade_reg;
    assign out_entry_count   = ocnt_reg;

endmodule

@@ design/fading_obstacle_circle_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fading_obstacle_circle_table_top
// Ring of obstacle circles with age-based fading, insert and point query.
// ----------------------------------------------------------------------------
// Input stream: one request per transfer, tuser selects insert (0) or query (1).
// Output stream: one result per request, in request order.
// Config: cfg_we/cfg_wdata write the fade time in ms; write only while idle.
// One request is processed at a time; only an insert fades entries, a
// query goes straight to the scan. The next request is taken the cycle
// after the result is loaded into the output register. The single read
// port of the entry RAM sets the processing time: the scan visits one
// entry per cycle, fading costs a read and a check per entry, and the
// containment test adds two pipeline stages.
// At reset the table is empty and the fade time is 15000 ms; RAM contents
// are not cleared. If the receiver stalls, the result holds in the output
// register and the block finishes the next request, then waits with it.
// ----------------------------------------------------------------------------
module fading_obstacle_circle_table_top #(
    parameter int CAPACITY = foct_pkg::CAP_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [31:0]                        cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // now_ms[31:0], pos_x[47:32], pos_y[63:48], circle_radius[75:64]
    input  logic [foct_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // mode[0]
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // hit[0], faded_count[6:1], entry_count[12:7]
    output logic [foct_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // insert_status[1:0]
    output logic [foct_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

    import foct_pkg::*;

    cmd_t                 cmd;
    sts_t                 sts;
    logic                 hit;
    logic [CNT_OUT_W-1:0] faded_count;
    logic [CNT_OUT_W-1:0] entry_count;

    foct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    foct_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_mode           (s_axis_tuser),
        .in_now_ms         (s_axis_tdata[31:0]),
        .in_pos_x          (s_axis_tdata[47:32]),
        .in_pos_y          (s_axis_tdata[63:48]),
        .in_circle_radius  (s_axis_tdata[75:64]),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .out_insert_status (m_axis_tuser),
        .out_hit           (hit),
        .out_faded_count   (faded_count),
        .out_entry_count   (entry_count)
    );

    assign m_axis_tdata = {3'b000, entry_count, faded_count, hit};

endmodule
